// File: rtl/dtwt_pkg.sv
package dtwt_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam int PRIO_LEVELS_DEF = 32;
    localparam int TICK_BITS_DEF   = 32;

    localparam int TASK_W  = 4;
    localparam int PRIO_W  = 5;
    localparam int DELAY_W = 32;
    localparam int TNOW_W  = 32;
    localparam int KIND_W  = 2;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_DELAY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_WOKEN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;

    typedef struct packed {
        logic               func;
        logic [TASK_W-1:0]  task_id;
        logic [PRIO_W-1:0]  task_prio;
        logic [DELAY_W-1:0] delay_ticks;
        logic [PRIO_W-1:0]  running_priority;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] woken_task;
        logic [PRIO_W-1:0] woken_priority;
        logic              preempts;
        logic [TNOW_W-1:0] tick_now;
        logic              last;
    } t_out;

endpackage

// File: rtl/delayed_task_wakeup_timer.sv
// Delay list for blocked tasks. A delay request (start with func 1) is acknowledged on
// the next cycle. When no task is due, a tick goes straight to its summary result.
// When the tick wraps the counter or reaches the next wake time, the block scans the
// task store through its single read port, one entry a cycle; each scan either wakes
// one task or ends the pass. Results leave as one-cycle strobes on o_res_valid that
// the receiver cannot stall, woken tasks first, earliest wake time first (ties by task
// index), then the tick summary marked last; busy stays high until the last result
// has been shown.
module delayed_task_wakeup_timer #(
    parameter int MAX_TASKS       = dtwt_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_LEVELS = dtwt_pkg::PRIO_LEVELS_DEF,
    parameter int TICK_BITS       = dtwt_pkg::TICK_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dtwt_pkg::t_in  i_item,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    output logic           o_res_valid,
    output dtwt_pkg::t_out o_res
);

    localparam int TIDW = $clog2(MAX_TASKS);
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int PW   = dtwt_pkg::PRIO_W;
    localparam int MW   = TICK_BITS + PW;
    localparam logic [TICK_BITS-1:0] TICK_ONES = '1;
    localparam logic [CNTW-1:0]      IDX_END   = CNTW'(MAX_TASKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SUMMARY
    } t_state;

    t_state                r_state;
    logic [TICK_BITS-1:0]  r_tick;
    logic [TICK_BITS-1:0]  r_next_wake;
    logic [MAX_TASKS-1:0]  r_waiting;
    logic [MAX_TASKS-1:0]  r_tag;
    logic                  r_cur_tag;
    logic                  r_time_slicing;
    logic [PW-1:0]         r_rprio;
    logic                  r_resched;
    logic [CNTW-1:0]       r_idx;
    logic                  r_cmp_vld;
    logic [TIDW-1:0]       r_cmp_idx;
    logic                  r_found;
    logic [TIDW-1:0]       r_best_idx;
    logic [TICK_BITS-1:0]  r_best_wake;
    logic [PW-1:0]         r_best_prio;
    logic                  r_out_vld;
    dtwt_pkg::t_out        r_out;

    logic                  accept;
    logic                  is_delay;
    logic [TICK_BITS-1:0]  tick_inc;
    logic                  tick_wrap;
    logic [TICK_BITS-1:0]  req_wake;
    logic [PW-1:0]         tprio_c;
    logic [PW-1:0]         rprio_c;
    logic                  tid_ok;
    logic [TIDW-1:0]       tid_idx;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [MW-1:0]         rd_data;
    logic [TICK_BITS-1:0]  rd_wake;
    logic [PW-1:0]         rd_prio;
    logic                  better;
    logic                  pre;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign is_delay  = (i_item.func != dtwt_pkg::FUNC_TICK);
    assign tick_inc  = r_tick + TICK_BITS'(1);
    assign tick_wrap = (tick_inc == '0);
    assign req_wake  = r_tick + TICK_BITS'(i_item.delay_ticks);
    assign tid_ok    = 32'(i_item.task_id) < 32'(MAX_TASKS);
    assign tid_idx   = TIDW'(i_item.task_id);

    assign tprio_c = (32'(i_item.task_prio) >= 32'(PRIORITY_LEVELS)) ?
                     PW'(PRIORITY_LEVELS - 1) : i_item.task_prio;
    assign rprio_c = (32'(i_item.running_priority) >= 32'(PRIORITY_LEVELS)) ?
                     PW'(PRIORITY_LEVELS - 1) : i_item.running_priority;

    assign ram_wr_en = accept && is_delay && tid_ok;
    assign ram_rd_en = (r_state == S_SCAN) && (r_idx != IDX_END);

    dtwt_ram #(
        .DEPTH(MAX_TASKS),
        .WIDTH(MW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (tid_idx),
        .i_wr_data ({tprio_c, req_wake}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx[TIDW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_wake = rd_data[TICK_BITS-1:0];
    assign rd_prio = rd_data[MW-1:TICK_BITS];
    assign better  = r_cmp_vld && r_waiting[r_cmp_idx] && (r_tag[r_cmp_idx] == r_cur_tag)
                     && (!r_found || (rd_wake < r_best_wake));
    assign pre     = (r_rprio > r_best_prio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tick         <= '0;
            r_next_wake    <= TICK_ONES;
            r_waiting      <= '0;
            r_tag          <= '0;
            r_cur_tag      <= 1'b0;
            r_time_slicing <= 1'b0;
            r_resched      <= 1'b0;
            r_idx          <= '0;
            r_cmp_vld      <= 1'b0;
            r_found        <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_wr_en) begin
                r_time_slicing <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_delay) begin
                            if (tid_ok) begin
                                r_waiting[tid_idx] <= 1'b1;
                                if (req_wake < r_tick) begin
                                    r_tag[tid_idx] <= ~r_cur_tag;
                                end else begin
                                    r_tag[tid_idx] <= r_cur_tag;
                                    if (req_wake < r_next_wake) begin
                                        r_next_wake <= req_wake;
                                    end
                                end
                            end
                            r_out_vld            <= 1'b1;
                            r_out.kind           <= dtwt_pkg::KIND_ACK;
                            r_out.woken_task     <= '0;
                            r_out.woken_priority <= '0;
                            r_out.preempts       <= 1'b0;
                            r_out.tick_now       <= dtwt_pkg::TNOW_W'(r_tick);
                            r_out.last           <= 1'b1;
                        end else begin
                            r_tick    <= tick_inc;
                            r_rprio   <= rprio_c;
                            r_resched <= 1'b0;
                            if (tick_wrap) begin
                                r_cur_tag <= ~r_cur_tag;
                            end
                            if (tick_wrap || (tick_inc >= r_next_wake)) begin
                                r_state   <= S_SCAN;
                                r_idx     <= '0;
                                r_found   <= 1'b0;
                                r_cmp_vld <= 1'b0;
                            end else begin
                                r_state <= S_SUMMARY;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (better) begin
                        r_found     <= 1'b1;
                        r_best_idx  <= r_cmp_idx;
                        r_best_wake <= rd_wake;
                        r_best_prio <= rd_prio;
                    end
                    if (r_idx != IDX_END) begin
                        r_idx     <= r_idx + CNTW'(1);
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_idx[TIDW-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    priority if (!r_found) begin
                        r_next_wake <= TICK_ONES;
                        r_state     <= S_SUMMARY;
                    end else if (r_tick < r_best_wake) begin
                        r_next_wake <= r_best_wake;
                        r_state     <= S_SUMMARY;
                    end else begin
                        r_waiting[r_best_idx] <= 1'b0;
                        r_resched             <= r_resched | pre;
                        r_out_vld             <= 1'b1;
                        r_out.kind            <= dtwt_pkg::KIND_WOKEN;
                        r_out.woken_task      <= dtwt_pkg::TASK_W'(r_best_idx);
                        r_out.woken_priority  <= r_best_prio;
                        r_out.preempts        <= pre;
                        r_out.tick_now        <= dtwt_pkg::TNOW_W'(r_tick);
                        r_out.last            <= 1'b0;
                        r_state               <= S_SCAN;
                        r_idx                 <= '0;
                        r_found               <= 1'b0;
                    end
                end
                S_SUMMARY: begin
                    r_out_vld            <= 1'b1;
                    r_out.kind           <= dtwt_pkg::KIND_SUMMARY;
                    r_out.woken_task     <= '0;
                    r_out.woken_priority <= '0;
                    r_out.preempts       <= r_resched | r_time_slicing;
                    r_out.tick_now       <= dtwt_pkg::TNOW_W'(r_tick);
                    r_out.last           <= 1'b1;
                    r_state              <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

`ifndef NO_ASSERTIONS
    a_woken_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == dtwt_pkg::KIND_WOKEN)) |-> !o_res.last)
        else $error("woken-task transaction marked last");

    a_tick_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(accept && !is_delay)) |=> $stable(r_tick))
        else $error("tick counter moved without a tick transaction");

    a_done_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_res_valid && o_res.last))
        else $error("busy dropped without a last transaction");
`endif

endmodule

// File: rtl/dtwt_ram.sv
module dtwt_ram #(
    parameter int DEPTH = dtwt_pkg::MAX_TASKS_DEF,
    parameter int WIDTH = dtwt_pkg::TICK_BITS_DEF + dtwt_pkg::PRIO_W,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/delayed_task_wakeup_timer_tb.sv
`timescale 1ns / 1ps

module delayed_task_wakeup_timer_tb;

    typedef struct packed {
        bit             cfg_row;
        bit             cfg_val;
        bit             fixed;
        dtwt_pkg::t_in  item;
        dtwt_pkg::t_out res;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    dtwt_pkg::t_in  i_item;
    logic           i_cfg_wr_en;
    logic           i_cfg_wr_data;
    logic           o_res_valid;
    dtwt_pkg::t_out o_res;

    bit [31:0]                 tick_count;
    bit [31:0]                 next_wake = '1;
    bit [31:0]                 wake_at [dtwt_pkg::MAX_TASKS_DEF];
    bit [dtwt_pkg::PRIO_W-1:0] prio_of [dtwt_pkg::MAX_TASKS_DEF];
    bit                        waiting [dtwt_pkg::MAX_TASKS_DEF];
    bit                        list_sel [dtwt_pkg::MAX_TASKS_DEF];
    bit                        cur_list;
    bit                        slicing;

    dtwt_pkg::t_out pending_events [$];
    int             mismatch_count;
    bit             hold_req;
    bit             steady;

    delayed_task_wakeup_timer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s, got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int earliest_waiting();
        int best;
        best = -1;
        for (int i = 0; i < dtwt_pkg::MAX_TASKS_DEF; i++) begin
            if (waiting[i] && list_sel[i] == cur_list && (best < 0 || wake_at[i] < wake_at[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic void predict_timer_step(input dtwt_pkg::t_in it);
        dtwt_pkg::t_out r;
        bit [31:0]      wake;
        bit             resched;
        bit             pre;
        bit             scanning;
        int             h;
        r = '0;
        if (it.func == dtwt_pkg::FUNC_DELAY) begin
            wake = tick_count + it.delay_ticks;
            wake_at[it.task_id] = wake;
            prio_of[it.task_id] = it.task_prio;
            waiting[it.task_id] = 1'b1;
            if (wake < tick_count) begin
                list_sel[it.task_id] = ~cur_list;
            end else begin
                list_sel[it.task_id] = cur_list;
                if (wake < next_wake)
                    next_wake = wake;
            end
            r.kind     = dtwt_pkg::KIND_ACK;
            r.tick_now = tick_count;
            r.last     = 1'b1;
            pending_events.push_back(r);
        end else begin
            resched = 1'b0;
            tick_count++;
            if (tick_count == 0) begin
                cur_list = ~cur_list;
                h = earliest_waiting();
                next_wake = (h < 0) ? '1 : wake_at[h];
            end
            if (tick_count >= next_wake) begin
                scanning = 1'b1;
                while (scanning) begin
                    h = earliest_waiting();
                    if (h < 0) begin
                        next_wake = '1;
                        scanning = 1'b0;
                    end else if (tick_count < wake_at[h]) begin
                        next_wake = wake_at[h];
                        scanning = 1'b0;
                    end else begin
                        waiting[h] = 1'b0;
                        wake_at[h] = '0;
                        pre = it.running_priority > prio_of[h];
                        resched |= pre;
                        r = '0;
                        r.kind           = dtwt_pkg::KIND_WOKEN;
                        r.woken_task     = h[dtwt_pkg::TASK_W-1:0];
                        r.woken_priority = prio_of[h];
                        r.preempts       = pre;
                        r.tick_now       = tick_count;
                        pending_events.push_back(r);
                    end
                end
            end
            if (slicing)
                resched = 1'b1;
            r = '0;
            r.kind     = dtwt_pkg::KIND_SUMMARY;
            r.preempts = resched;
            r.tick_now = tick_count;
            r.last     = 1'b1;
            pending_events.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        dtwt_pkg::t_out want;
        if (i_rst_n && o_res_valid) begin
            if (pending_events.size() == 0) begin
                flag_mismatch("unexpected transaction, tick_now", o_res.tick_now, '0);
            end else begin
                want = pending_events.pop_front();
                if (o_res.kind != want.kind)
                    flag_mismatch("kind", 32'(o_res.kind), 32'(want.kind));
                if (o_res.woken_task != want.woken_task)
                    flag_mismatch("woken_task", 32'(o_res.woken_task),
                                  32'(want.woken_task));
                if (o_res.woken_priority != want.woken_priority)
                    flag_mismatch("woken_priority", 32'(o_res.woken_priority),
                                  32'(want.woken_priority));
                if (o_res.preempts != want.preempts)
                    flag_mismatch("preempts", 32'(o_res.preempts), 32'(want.preempts));
                if (o_res.tick_now != want.tick_now)
                    flag_mismatch("tick_now", o_res.tick_now, want.tick_now);
                if (o_res.last != want.last)
                    flag_mismatch("last", 32'(o_res.last), 32'(want.last));
            end
        end
    end

    task automatic push_request(input dtwt_pkg::t_in it, input bit fixed,
                                input dtwt_pkg::t_out res);
        if (!hold_req)
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_timer_step(it);
        if (fixed) begin
            void'(pending_events.pop_back());
            pending_events.push_back(res);
        end
        hold_req = steady || ($urandom_range(0, 99) >= 37);
        if (!hold_req)
            start <= 1'b0;
    endtask

    task automatic release_requests();
        if (hold_req)
            start <= 1'b0;
        hold_req = 1'b0;
    endtask

    task automatic write_slicing(input bit v);
        release_requests();
        while (busy || pending_events.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        slicing = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_row delay_row(input logic [dtwt_pkg::TASK_W-1:0] id,
                                       input logic [dtwt_pkg::PRIO_W-1:0] prio,
                                       input logic [31:0] ticks,
                                       input logic [dtwt_pkg::PRIO_W-1:0] rp);
        t_row r;
        r = '0;
        r.item.func             = dtwt_pkg::FUNC_DELAY;
        r.item.task_id          = id;
        r.item.task_prio        = prio;
        r.item.delay_ticks      = ticks;
        r.item.running_priority = rp;
        return r;
    endfunction

    function automatic t_row tick_row(input logic [dtwt_pkg::PRIO_W-1:0] rp);
        t_row r;
        r = '0;
        r.item.func             = dtwt_pkg::FUNC_TICK;
        r.item.running_priority = rp;
        return r;
    endfunction

    function automatic t_row cfg_row(input bit v);
        t_row r;
        r = '0;
        r.cfg_row = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic t_row pinned(input t_row r, input logic [dtwt_pkg::KIND_W-1:0] kind,
                                    input logic [31:0] now, input bit pre);
        t_row p;
        p = r;
        p.fixed        = 1'b1;
        p.res          = '0;
        p.res.kind     = kind;
        p.res.tick_now = now;
        p.res.preempts = pre;
        p.res.last     = 1'b1;
        return p;
    endfunction

    function automatic dtwt_pkg::t_in random_request();
        dtwt_pkg::t_in it;
        int            sel;
        it.func             = ($urandom_range(0, 99) < 55) ? dtwt_pkg::FUNC_DELAY :
                                                             dtwt_pkg::FUNC_TICK;
        it.task_id          = 4'($urandom_range(0, 15));
        it.task_prio        = 5'($urandom_range(0, 31));
        it.running_priority = 5'($urandom_range(0, 31));
        sel = $urandom_range(0, 9);
        case (sel)
            6: begin
                it.delay_ticks = '0;
            end
            7: begin
                it.delay_ticks = $urandom;
            end
            8: begin
                it.delay_ticks = 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            9: begin
                it.delay_ticks = $urandom_range(7, 40);
            end
            default: begin
                it.delay_ticks = $urandom_range(0, 6);
            end
        endcase
        return it;
    endfunction

    initial begin
        t_row plan [$];
        bit   phase_val;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_item        <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_slicing(1'b0);

        plan = '{
            pinned(tick_row(5'd0), dtwt_pkg::KIND_SUMMARY, 32'd1, 1'b0),
            pinned(delay_row(4'd0, 5'd31, 32'd0, 5'd0), dtwt_pkg::KIND_ACK, 32'd1, 1'b0),
            pinned(delay_row(4'd15, 5'd0, 32'hFFFF_FFFF, 5'd0), dtwt_pkg::KIND_ACK,
                   32'd1, 1'b0),
            delay_row(4'd5, 5'd10, 32'd1, 5'd31),
            delay_row(4'd6, 5'd10, 32'd1, 5'd31),
            tick_row(5'd31),
            delay_row(4'd3, 5'd4, 32'd3, 5'd0),
            delay_row(4'd3, 5'd20, 32'd1, 5'd0),
            tick_row(5'd0),
            delay_row(4'd7, 5'd2, 32'd5, 5'd0),
            delay_row(4'd8, 5'd1, 32'd2, 5'd0),
            delay_row(4'd8, 5'd1, 32'd10, 5'd0),
            tick_row(5'd0),
            tick_row(5'd0),
            cfg_row(1'b1),
            pinned(tick_row(5'd5), dtwt_pkg::KIND_SUMMARY, 32'd6, 1'b1),
            cfg_row(1'b0),
            delay_row(4'd15, 5'd31, 32'hFFFF_FFFF, 5'd0),
            tick_row(5'd31),
            tick_row(5'd31),
            delay_row(4'd9, 5'd0, 32'h8000_0000, 5'd31),
            delay_row(4'd10, 5'd31, 32'h7FFF_FFFF, 5'd0),
            delay_row(4'd11, 5'd16, 32'd0, 5'd0),
            tick_row(5'd16)
        };

        foreach (plan[i]) begin
            if (plan[i].cfg_row)
                write_slicing(plan[i].cfg_val);
            else
                push_request(plan[i].item, plan[i].fixed, plan[i].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            phase_val = (ph == 3) ? 1'($urandom_range(0, 1)) : 1'(ph == 1);
            write_slicing(phase_val);
            steady = (ph == 2);
            repeat (25) push_request(random_request(), 1'b0, '0);
        end

        release_requests();
        while (busy || pending_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
